// ----- design/sqp_pkg.sv -----
// ----------------------------------------------------------------------------
// sqp_pkg
// Types and constants shared by the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package sqp_pkg;

  localparam int unsigned DEPTH_DEF = 128;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PRIO_W    = 8;
  localparam int unsigned CNT_OUT_W = 8;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    req_kind_t                 req_type;
    logic signed [DATA_W-1:0]  item_data;
    logic        [PRIO_W-1:0]  item_priority;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  out_data;
    logic        [PRIO_W-1:0]  out_priority;
    logic     [CNT_OUT_W-1:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic        [PRIO_W-1:0] prio;
  } entry_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t item;
  } cell_ctrl_t;

endpackage

// ----- design/sqp_cell.sv -----
// ----------------------------------------------------------------------------
// sqp_cell
// One slot of the sorted row: keeps, takes the new word, or shifts a neighbor.
// ----------------------------------------------------------------------------
module sqp_cell
  import sqp_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       live,
  input  logic       left_gt,
  input  entry_t     left_entry,
  input  entry_t     right_entry,
  output logic       gt,
  output entry_t     entry
);

  // this slot stays ahead of the new word
  assign gt = live && (entry.prio > ctrl.item.prio);

  always_ff @(posedge clk) begin
    if (ctrl.deq) begin
      entry <= right_entry;
    end else if (ctrl.enq && !gt) begin
      if (left_gt) begin
        entry <= ctrl.item;
      end else begin
        entry <= left_entry;
      end
    end
  end

endmodule

// ----- design/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue held as a row of sorted cells, highest priority at the head.
// ----------------------------------------------------------------------------
// One request word is taken every clock cycle; busy is always low. The result
// word appears on rsp with done high in the cycle after start, written along
// with the update of the cell row: every cell compares its priority with
// the new word at once and shifts in parallel. An enqueue goes ahead of all
// entries of equal or lower priority; a dequeue returns the head. The receiver
// cannot stall and must take each result in its cycle.
module sorted_priority_queue
  import sqp_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  cell_ctrl_t       ctrl;
  entry_t           cells [DEPTH];
  logic [DEPTH-1:0] gt;
  logic             full;
  logic             empty;
  logic             take;
  rsp_t             rsp_next;

  assign busy  = 1'b0;
  assign take  = start && !busy;
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    ctrl.enq       = take && (req.req_type == REQ_ENQ) && !full;
    ctrl.deq       = take && (req.req_type == REQ_DEQ) && !empty;
    ctrl.item.data = req.item_data;
    ctrl.item.prio = req.item_priority;
  end

  always_comb begin
    count_next = count;
    if (ctrl.enq) begin
      count_next = count + CW'(1);
    end else if (ctrl.deq) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    rsp_next.status       = ST_OK;
    rsp_next.out_data     = '0;
    rsp_next.out_priority = '0;
    rsp_next.entry_count  = CNT_OUT_W'(count_next);
    unique case (req.req_type)
      REQ_ENQ: begin
        if (full) rsp_next.status = ST_OVERFLOW;
      end
      REQ_DEQ: begin
        if (empty) begin
          rsp_next.status = ST_UNDERFLOW;
        end else begin
          rsp_next.out_data     = cells[0].data;
          rsp_next.out_priority = cells[0].prio;
        end
      end
      default: rsp_next.status = ST_OK;
    endcase
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic   live;
      logic   left_gt;
      entry_t left_entry;
      entry_t right_entry;

      assign live = (CW'(i) < count);

      if (i == 0) begin : g_head
        assign left_gt    = 1'b1;
        assign left_entry = ctrl.item;
      end else begin : g_body
        assign left_gt    = gt[i-1];
        assign left_entry = cells[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign right_entry = cells[i];
      end else begin : g_mid
        assign right_entry = cells[i+1];
      end

      sqp_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .live        (live),
        .left_gt     (left_gt),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .gt          (gt[i]),
        .entry       (cells[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) rsp <= rsp_next;
  end

  // every accepted request yields one result word in the next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> done)
    else $error("missing result word");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_OVERFLOW) |-> (full && $stable(count)))
    else $error("overflow while not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_UNDERFLOW) |-> (empty && $stable(count)))
    else $error("underflow while not empty");

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_priority_queue: drives enqueue and dequeue
// words with random gaps, predicts each result from a sorted model of the
// queue, and compares every strobed result field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sqp_pkg::*;

  localparam int WATCHDOG_LIMIT = 100;
  localparam int RANDOM_ITEMS   = 700;
  localparam int MAX_GAP        = 13;

  // sorted model of the queue plus the results it predicts
  class pq_scoreboard;
    entry_t rows[$];
    rsp_t   pending_rsps[$];
    int     errors;

    function void note_request(req_t w);
      rsp_t   e;
      entry_t ent;
      int     pos;
      e = '0;
      if (w.req_type == REQ_ENQ) begin
        if (rows.size() >= DEPTH_DEF) begin
          e.status = ST_OVERFLOW;
        end else begin
          // newest goes ahead of equal priorities
          pos = 0;
          while (pos < rows.size() && rows[pos].prio > w.item_priority) pos++;
          ent.data = w.item_data;
          ent.prio = w.item_priority;
          rows.insert(pos, ent);
          e.status = ST_OK;
        end
      end else begin
        if (rows.size() == 0) begin
          e.status = ST_UNDERFLOW;
        end else begin
          e.status       = ST_OK;
          e.out_data     = rows[0].data;
          e.out_priority = rows[0].prio;
          void'(rows.pop_front());
        end
      end
      e.entry_count = CNT_OUT_W'(rows.size());
      pending_rsps.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (pending_rsps.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result word with nothing pending: %p", got);
        return;
      end
      e = pending_rsps.pop_front();
      if (got.status !== e.status || got.out_data !== e.out_data ||
          got.out_priority !== e.out_priority || got.entry_count !== e.entry_count) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: status %0d/%0d data %h/%h prio %0d/%0d count %0d/%0d (exp/act)",
                   e.status, got.status, e.out_data, got.out_data,
                   e.out_priority, got.out_priority, e.entry_count, got.entry_count);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;

  pq_scoreboard sb;
  int  idle_cycles;
  bit  no_idle;

  sorted_priority_queue #(.DEPTH(DEPTH_DEF)) DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sample on the edge; stimulus lands by NBA afterwards
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done) sb.check_response(rsp);
      if (start && !busy) sb.note_request(req);
      if (done || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("sorted_priority_queue regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic req_t make_word(req_kind_t kind, logic [DATA_W-1:0] data,
                                     logic [PRIO_W-1:0] prio);
    req_t w;
    w.req_type      = kind;
    w.item_data     = data;
    w.item_priority = prio;
    return w;
  endfunction

  // holds start high until the word is taken; start stays high for a back-to-back word
  task automatic send_word(req_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random_run(int len, int enq_pct);
    logic [PRIO_W-1:0] prio;
    req_kind_t         kind;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 3))
        0: prio = PRIO_W'($urandom_range(0, 255));
        1: prio = PRIO_W'($urandom_range(0, 3));        // dense ties
        2: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: prio = PRIO_W'($urandom_range(120, 135));
      endcase
      kind = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
      send_word(make_word(kind, $urandom, prio));
    end
  endtask

  initial begin
    int sent;
    int len;
    sb      = new();
    no_idle = 1'b0;
    rst     <= 1'b1;
    start   <= 1'b0;
    req     <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: underflow, data/priority extremes, ties at top and bottom
    send_word(make_word(REQ_DEQ, 32'h0000_0000, 8'h00));
    send_word(make_word(REQ_ENQ, 32'h7FFF_FFFF, 8'hFF));
    send_word(make_word(REQ_ENQ, 32'h8000_0000, 8'h00));
    send_word(make_word(REQ_ENQ, 32'h0000_0000, 8'hFF));
    send_word(make_word(REQ_ENQ, 32'hFFFF_FFFF, 8'h80));
    send_word(make_word(REQ_ENQ, 32'h0000_0001, 8'h00));
    send_word(make_word(REQ_ENQ, 32'h5555_5555, 8'h80));
    send_word(make_word(REQ_ENQ, 32'hAAAA_AAAA, 8'h7F));
    for (int i = 0; i < 7; i++)
      send_word(make_word(REQ_DEQ, $urandom, PRIO_W'($urandom_range(0, 255))));
    send_word(make_word(REQ_DEQ, 32'hFFFF_FFFF, 8'hFF));
    send_word(make_word(REQ_ENQ, 32'h1234_5678, 8'h01));
    send_word(make_word(REQ_DEQ, 32'h0000_0000, 8'h00));
    send_word(make_word(REQ_DEQ, 32'h0000_0000, 8'h00));

    // fill past full for overflow, then drain past empty
    no_idle = 1'b1;
    send_random_run(DEPTH_DEF + 8, 100);
    no_idle = 1'b0;
    send_random_run(DEPTH_DEF + 8, 0);
    sent = 2 * (DEPTH_DEF + 8);

    while (sent < RANDOM_ITEMS) begin
      len     = $urandom_range(10, 60);
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: send_random_run(len, 85);
        1: send_random_run(len, 15);
        default: send_random_run(len, 50);
      endcase
      sent += len;
    end
    start <= 1'b0;

    while (sb.pending_rsps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("sorted_priority_queue regression: pass");
    end else begin
      $display("sorted_priority_queue regression: fail");
    end
    $finish;
  end

endmodule
